// ----- design/dpc_pkg.sv -----
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared constants and types for the drive distance P controller: register
// indexes, reset values, clamp thresholds and stream widths.
// ----------------------------------------------------------------------------
package dpc_pkg;

	// Default encoder count width
	localparam int COUNT_BITS_DEF = 20;

	// Configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 19;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_TARGET_DISTANCE = 3'd0,
		CFG_P_GAIN          = 3'd1,
		CFG_DRIFT_GAIN      = 3'd2,
		CFG_SPEED_CAP       = 3'd3,
		CFG_SETTLE_TICKS    = 3'd4
	} cfg_index_t;

	// Register widths
	localparam int GAIN_W   = 16;
	localparam int CAP_W    = 7;
	localparam int SETTLE_W = 8;

	// Register reset values
	localparam logic [GAIN_W-1:0]   P_GAIN_RST       = 16'd6095;
	localparam logic [GAIN_W-1:0]   DRIFT_GAIN_RST   = 16'd3146;
	localparam logic [CAP_W-1:0]    SPEED_CAP_RST    = 7'd80;
	localparam logic [SETTLE_W-1:0] SETTLE_TICKS_RST = 8'd15;

	// Speed scaling and clamp thresholds, in 1/256 percent
	localparam int FRAC_BITS    = 8;
	localparam int NEG_DEAD_LIM = -3 * 256;
	localparam int NEG_SET      = -5 * 256;
	localparam int POS_MIN      = 10 * 256;
	localparam int CAP_MAX      = 127 * 256;

	// Output speed range
	localparam int SPEED_W  = 16;
	localparam int SPEED_HI = 32767;
	localparam int SPEED_LO = -32768;

	// Result stream: left_speed, right_speed, at_target, finished
	localparam int OUT_BITS = 2 * SPEED_W + 2;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

endpackage

// ----- design/drive_distance_p_controller_unit.sv -----
// ----------------------------------------------------------------------------
// drive_distance_p_controller_unit
// Proportional drive-distance controller with speed clamps, left-right drift
// correction and a settle counter that ends the move.
// ----------------------------------------------------------------------------
//
// Usage:
//   s_* carries one control tick: start_move, right_count, left_count.
//   m_* returns one result per tick: left_speed, right_speed, at_target,
//   finished. cfg_* writes the five setup registers (target distance, P gain,
//   drift gain, speed cap, settle ticks); cfg_ready is always high and writes
//   are expected only while no tick is in flight.
//   A tick lands in the input register, then the gain multiplies, clamps,
//   saturation and settle logic run in a single pass into the result
//   register, which drives m_tvalid. A new tick is taken in every cycle
//   while the receiver takes results; the pass through the two multipliers
//   sets the cycle time.
//   When the receiver stalls, the result register holds its item and the
//   input register still takes one more tick; s_tready then drops until the
//   result is taken. Controller state (last right count, first-tick flag,
//   settle counter, move-done flag) advances as a tick moves into the result
//   register, so back-to-back ticks see each other's updates.
//   Reset clears both stages and the controller state and loads the default
//   register values; the block runs without a start_move pulse after reset.
//
module drive_distance_p_controller_unit #(
	parameter int COUNT_BITS = dpc_pkg::COUNT_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Tick input; s_tdata: start_move, right_count, left_count (LSB first)
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((2*COUNT_BITS+1+7)/8)*8-1:0]   s_tdata,
	// Result output; m_tdata: left_speed, right_speed, at_target, finished
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [dpc_pkg::OUT_W-1:0]             m_tdata,
	// Configuration writes
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [dpc_pkg::CFG_INDEX_W-1:0]       cfg_index,
	input  logic [dpc_pkg::CFG_DATA_W-1:0]        cfg_data
);

	localparam int C  = COUNT_BITS;
	localparam int TW = COUNT_BITS - 1;
	localparam int PW = COUNT_BITS + 1 + dpc_pkg::GAIN_W + 1;
	localparam int SW = PW - dpc_pkg::FRAC_BITS;
	localparam int WW = COUNT_BITS + 4;
	localparam int SPW = dpc_pkg::SPEED_W;

	localparam logic signed [SW-1:0] NEG_LIM_X = SW'(dpc_pkg::NEG_DEAD_LIM);
	localparam logic signed [SW-1:0] NEG_SET_X = SW'(dpc_pkg::NEG_SET);
	localparam logic signed [SW-1:0] POS_MIN_X = SW'(dpc_pkg::POS_MIN);
	localparam logic signed [SW-1:0] ZERO_X    = '0;
	localparam logic signed [SW:0]   SAT_HI_X  = (SW+1)'(dpc_pkg::SPEED_HI);
	localparam logic signed [SW:0]   SAT_LO_X  = (SW+1)'(dpc_pkg::SPEED_LO);
	localparam logic signed [C:0]    DELTA_HI  = (C+1)'(1);
	localparam logic signed [C:0]    DELTA_LO  = (C+1)'(-1);
	localparam logic [dpc_pkg::SETTLE_W-1:0] SETTLE_MAX = '1;

	// Configuration registers
	logic [TW-1:0]                    target_q;
	logic [dpc_pkg::GAIN_W-1:0]       p_gain_q;
	logic [dpc_pkg::GAIN_W-1:0]       drift_gain_q;
	logic [dpc_pkg::CAP_W-1:0]        speed_cap_q;
	logic [dpc_pkg::SETTLE_W-1:0]     settle_ticks_q;

	// Controller state
	logic signed [C-1:0]              last_right_q;
	logic                             past_first_q;
	logic [dpc_pkg::SETTLE_W-1:0]     settle_q;
	logic                             done_q;

	// Input stage
	logic                             valid_s1;
	logic                             start_s1;
	logic signed [C-1:0]              right_s1;
	logic signed [C-1:0]              left_s1;

	// Result stage
	logic                             valid_s2;
	logic [dpc_pkg::OUT_W-1:0]        data_s2;

	logic                             load_s2;
	logic                             adv_s1;

	// Datapath
	logic signed [C:0]                tgt_x;
	logic signed [C:0]                right_x;
	logic signed [C:0]                left_x;
	logic signed [C:0]                err_x;
	logic signed [C:0]                diff_x;
	logic signed [PW-1:0]             p_prod;
	logic signed [PW-1:0]             d_prod;
	logic signed [SW-1:0]             speed_raw;
	logic signed [SW-1:0]             drift_x;
	logic signed [SW-1:0]             cap_x;
	logic signed [SW-1:0]             speed_cl;
	logic signed [SW:0]               left_sum;
	logic signed [WW-1:0]             right_w;
	logic signed [WW-1:0]             right5_w;
	logic signed [WW-1:0]             target4_w;
	logic                             in_window;
	logic signed [C:0]                delta_x;
	logic                             reached;
	logic                             done_eff;
	logic                             past_eff;
	logic signed [C-1:0]              last_eff;
	logic [dpc_pkg::SETTLE_W-1:0]     settle_eff;
	logic [dpc_pkg::SETTLE_W-1:0]     settle_nx;
	logic                             done_nx;
	logic                             fin;
	logic signed [SPW-1:0]            left_out;
	logic signed [SPW-1:0]            right_out;

	function automatic logic signed [SPW-1:0] sat16(input logic signed [SW:0] x);
		logic signed [SPW-1:0] r;
		if (x > SAT_HI_X) begin
			r = SPW'(dpc_pkg::SPEED_HI);
		end else if (x < SAT_LO_X) begin
			r = SPW'(dpc_pkg::SPEED_LO);
		end else begin
			r = x[SPW-1:0];
		end
		return r;
	endfunction

	// Handshake: result register frees on transfer, input stage follows
	assign load_s2   = !valid_s2 || m_tready;
	assign adv_s1    = valid_s1 && load_s2;
	assign s_tready  = !valid_s1 || load_s2;
	assign m_tvalid  = valid_s2;
	assign m_tdata   = data_s2;
	assign cfg_ready = 1'b1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q       <= '0;
			p_gain_q       <= dpc_pkg::P_GAIN_RST;
			drift_gain_q   <= dpc_pkg::DRIFT_GAIN_RST;
			speed_cap_q    <= dpc_pkg::SPEED_CAP_RST;
			settle_ticks_q <= dpc_pkg::SETTLE_TICKS_RST;
		end else if (cfg_valid) begin
			unique case (dpc_pkg::cfg_index_t'(cfg_index))
				dpc_pkg::CFG_TARGET_DISTANCE: target_q <= TW'(cfg_data);
				dpc_pkg::CFG_P_GAIN:       p_gain_q       <= cfg_data[dpc_pkg::GAIN_W-1:0];
				dpc_pkg::CFG_DRIFT_GAIN:   drift_gain_q   <= cfg_data[dpc_pkg::GAIN_W-1:0];
				dpc_pkg::CFG_SPEED_CAP:    speed_cap_q    <= cfg_data[dpc_pkg::CAP_W-1:0];
				dpc_pkg::CFG_SETTLE_TICKS: settle_ticks_q <= cfg_data[dpc_pkg::SETTLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			start_s1 <= s_tdata[0];
			right_s1 <= s_tdata[C:1];
			left_s1  <= s_tdata[2*C:C+1];
		end
	end

	// Error and drift products
	always_comb begin
		tgt_x     = $signed({2'b00, target_q});
		right_x   = {right_s1[C-1], right_s1};
		left_x    = {left_s1[C-1], left_s1};
		err_x     = tgt_x - right_x;
		diff_x    = right_x - left_x;
		p_prod    = PW'(err_x) * $signed(PW'({1'b0, p_gain_q}));
		d_prod    = PW'(diff_x) * $signed(PW'({1'b0, drift_gain_q}));
		speed_raw = p_prod[PW-1:dpc_pkg::FRAC_BITS];
		drift_x   = d_prod[PW-1:dpc_pkg::FRAC_BITS];
		cap_x     = $signed(SW'({1'b0, speed_cap_q, 8'h00}));
	end

	// Clamp the base speed in order: cap, negative dead band, positive minimum
	always_comb begin
		speed_cl = speed_raw;
		if (speed_cl > cap_x) begin
			speed_cl = cap_x;
		end
		if (speed_cl < ZERO_X && speed_cl > NEG_LIM_X) begin
			speed_cl = NEG_SET_X;
		end
		if (speed_cl > ZERO_X && speed_cl < POS_MIN_X) begin
			speed_cl = POS_MIN_X;
		end
	end

	// Add drift to the left side below 0.8 of the target
	always_comb begin
		right_w   = WW'(right_x);
		right5_w  = (right_w <<< 2) + right_w;
		target4_w = WW'(tgt_x) <<< 2;
		in_window = right5_w < target4_w;
		if (in_window) begin
			left_sum = (SW+1)'(speed_cl) + (SW+1)'(drift_x);
		end else begin
			left_sum = (SW+1)'(speed_cl);
		end
	end

	// Settle counter and move end
	always_comb begin
		done_eff   = done_q && !start_s1;
		past_eff   = past_first_q && !start_s1;
		last_eff   = start_s1 ? '0 : last_right_q;
		settle_eff = start_s1 ? '0 : settle_q;
		reached    = right_x >= tgt_x;
		delta_x    = {last_eff[C-1], last_eff} - right_x;
		if (reached || (past_eff && delta_x >= DELTA_LO && delta_x <= DELTA_HI)) begin
			settle_nx = (settle_eff == SETTLE_MAX) ? settle_eff : settle_eff + 1'b1;
		end else begin
			settle_nx = '0;
		end
		done_nx = settle_nx >= settle_ticks_q;
		fin     = done_eff || done_nx;
		if (fin) begin
			left_out  = '0;
			right_out = '0;
		end else begin
			left_out  = sat16(left_sum);
			right_out = sat16((SW+1)'(speed_cl));
		end
	end

	// Advance controller state; freeze once the move is done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_right_q <= '0;
			past_first_q <= 1'b0;
			settle_q     <= '0;
			done_q       <= 1'b0;
		end else if (adv_s1 && !done_eff) begin
			last_right_q <= right_s1;
			past_first_q <= 1'b1;
			settle_q     <= settle_nx;
			done_q       <= done_nx;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_s2 <= dpc_pkg::OUT_W'({fin, reached, right_out, left_out});
		end
	end

endmodule

// ----- design/dpc_checker.sv -----
// ----------------------------------------------------------------------------
// dpc_checker
// Port-level checks for the drive distance P controller, bound to the top.
// ----------------------------------------------------------------------------
module dpc_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tready,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic [dpc_pkg::OUT_W-1:0]             m_tdata
);

	localparam int SPW = dpc_pkg::SPEED_W;
	localparam int AT  = 2 * SPW;
	localparam int FN  = 2 * SPW + 1;

	logic signed [SPW-1:0] left_spd;
	logic signed [SPW-1:0] right_spd;

	assign left_spd  = $signed(m_tdata[SPW-1:0]);
	assign right_spd = $signed(m_tdata[2*SPW-1:SPW]);

	// Hold a stalled result
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// Take a tick whenever the result register is empty
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input not ready with an empty result register");

	// Brake on a finished move
	a_finish_brake: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[FN] |-> left_spd == '0 && right_spd == '0)
		else $error("finished result with nonzero speed");

	// Right speed stays out of the clamp bands and under the largest cap
	a_right_band: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> right_spd == '0
			|| (right_spd >= SPW'(dpc_pkg::POS_MIN) && right_spd <= SPW'(dpc_pkg::CAP_MAX))
			|| right_spd <= SPW'(dpc_pkg::NEG_DEAD_LIM))
		else $error("right speed inside a clamp band");

	// Padding bits above the packed fields stay zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[dpc_pkg::OUT_W-1:FN+1] == '0)
		else $error("padding bits set, at_target %0b", m_tdata[AT]);

endmodule

bind drive_distance_p_controller_unit dpc_checker u_dpc_checker (.*);
